// ----- hdl/dws_pkg.sv -----
// Shared types, constants and ring index helpers for the deque with search.
package dws_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 2;
  localparam int STAT_W   = 2;
  localparam int LEN_W    = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 2'd0,
    FN_PUSH_BACK  = 2'd1,
    FN_POP_BACK   = 2'd2,
    FN_SEARCH     = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  // Step one slot forward around the ring.
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    if (idx == IDX_W'(CAPACITY - 1)) begin
      return '0;
    end
    return idx + IDX_W'(1);
  endfunction

  // Step one slot back around the ring.
  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
    if (idx == '0) begin
      return IDX_W'(CAPACITY - 1);
    end
    return idx - IDX_W'(1);
  endfunction

  // Slot that lies cnt places after idx; the sum stays below twice the capacity.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] cnt);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(idx) + (CNT_W+1)'(cnt);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ----- hdl/deque_with_search.sv -----
// Top level of the bounded deque with value search over a ring store.
//
//   channel  handshake              payload
//   req      req_valid / req_stall  func[1:0], item[31:0] signed
//   rsp      rsp_valid / rsp_stall  status[1:0], found, length[4:0]
//
// An insert writes the store in the cycle its item is accepted; for inserts and
// removes the result is registered at the same edge.
// A search of n held items makes one store read per held entry through the
// single read port, each compared in the cycle after its read; with none held
// no read is made. rst clears the state, the front pointer, the count and the
// result valid; the store itself needs no clearing since only held entries are read.
// req_stall rises during a search and while a result waits under rsp_stall.
module deque_with_search (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [dws_pkg::FUNC_W-1:0]        func,
  input  logic signed [dws_pkg::DATA_W-1:0] item,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [dws_pkg::STAT_W-1:0]        status,
  output logic                              found,
  output logic [dws_pkg::LEN_W-1:0]         length
);

  // Write and read requests from the sequencer into the store.
  dws_pkg::wr_req_t           wr;
  dws_pkg::rd_req_t           rd;
  logic [dws_pkg::DATA_W-1:0] rd_data;

  // Sequencer: decode each item, move the ring pointers, run the search pass.
  dws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .func      (func),
    .item      (item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .found     (found),
    .length    (length),
    .wr        (wr),
    .rd        (rd),
    .rd_data   (rd_data)
  );

  // Ring store of held items, read data registered in the cycle after the address.
  dws_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

endmodule

// ----- hdl/dws_store.sv -----
// Ring store of the held items: one write port, one read port with registered data.
module dws_store (
  input  logic                           clk,
  input  dws_pkg::wr_req_t               wr,
  input  dws_pkg::rd_req_t               rd,
  output logic [dws_pkg::DATA_W-1:0]     rd_data
);

  logic [dws_pkg::DATA_W-1:0] mem [dws_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// ----- hdl/dws_ctrl.sv -----
// Request sequencer: ring pointers, search pass over the store, result register.
module dws_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [dws_pkg::FUNC_W-1:0]     func,
  input  logic signed [dws_pkg::DATA_W-1:0] item,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [dws_pkg::STAT_W-1:0]     status,
  output logic                           found,
  output logic [dws_pkg::LEN_W-1:0]      length,
  output dws_pkg::wr_req_t               wr,
  output dws_pkg::rd_req_t               rd,
  input  logic [dws_pkg::DATA_W-1:0]     rd_data
);

  dws_pkg::state_t               state, state_next;
  logic [dws_pkg::IDX_W-1:0]     front, front_next;
  logic [dws_pkg::CNT_W-1:0]     count, count_next;
  logic [dws_pkg::IDX_W-1:0]     rd_ptr, rd_ptr_next;
  logic [dws_pkg::CNT_W-1:0]     rd_left, rd_left_next;
  logic                          hit, hit_next;
  logic [dws_pkg::DATA_W-1:0]    key, key_next;
  logic                          rsp_valid_next;

  logic                          load;
  dws_pkg::status_t              load_status;
  logic                          load_found;
  logic [dws_pkg::CNT_W-1:0]     load_count;
  logic                          hit_acc;
  logic [dws_pkg::IDX_W-1:0]     new_front;
  logic                          full;
  logic                          accept;

  assign full      = (count == dws_pkg::CNT_W'(dws_pkg::CAPACITY));
  assign req_stall = (state != dws_pkg::S_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign hit_acc   = hit || (rd_data == key);
  assign new_front = dws_pkg::idx_dec(front);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dws_pkg::S_IDLE;
      front     <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      front     <= front_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr  <= rd_ptr_next;
    rd_left <= rd_left_next;
    hit     <= hit_next;
    key     <= key_next;
    if (load) begin
      status <= load_status;
      found  <= load_found;
      length <= dws_pkg::LEN_W'(load_count);
    end
  end

  always_comb begin
    state_next   = state;
    front_next   = front;
    count_next   = count;
    rd_ptr_next  = rd_ptr;
    rd_left_next = rd_left;
    hit_next     = hit;
    key_next     = key;
    wr           = '0;
    rd           = '0;
    load         = 1'b0;
    load_status  = dws_pkg::ST_OK;
    load_found   = 1'b0;
    load_count   = count;

    unique case (state)
      dws_pkg::S_IDLE: begin
        if (accept) begin
          load = 1'b1;
          unique case (dws_pkg::func_t'(func))
            dws_pkg::FN_PUSH_FRONT: begin
              if (full) begin
                load_status = dws_pkg::ST_FULL;
              end else begin
                wr.en      = 1'b1;
                wr.addr    = new_front;
                wr.data    = item;
                front_next = new_front;
                count_next = count + dws_pkg::CNT_W'(1);
                load_count = count_next;
              end
            end
            dws_pkg::FN_PUSH_BACK: begin
              if (full) begin
                load_status = dws_pkg::ST_FULL;
              end else begin
                wr.en      = 1'b1;
                wr.addr    = dws_pkg::ring_add(front, count);
                wr.data    = item;
                count_next = count + dws_pkg::CNT_W'(1);
                load_count = count_next;
              end
            end
            dws_pkg::FN_POP_BACK: begin
              if (count == '0) begin
                load_status = dws_pkg::ST_EMPTY;
              end else begin
                count_next = count - dws_pkg::CNT_W'(1);
                load_count = count_next;
              end
            end
            dws_pkg::FN_SEARCH: begin
              if (count != '0) begin
                // Hold the result until the pass ends; issue the first read now.
                load         = 1'b0;
                rd.en        = 1'b1;
                rd.addr      = front;
                rd_ptr_next  = dws_pkg::idx_inc(front);
                rd_left_next = count - dws_pkg::CNT_W'(1);
                hit_next     = 1'b0;
                key_next     = item;
                state_next   = dws_pkg::S_SEARCH;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      dws_pkg::S_SEARCH: begin
        // Compare the entry read last cycle; advance while reads remain.
        if (rd_left != '0) begin
          rd.en        = 1'b1;
          rd.addr      = rd_ptr;
          rd_ptr_next  = dws_pkg::idx_inc(rd_ptr);
          rd_left_next = rd_left - dws_pkg::CNT_W'(1);
          hit_next     = hit_acc;
        end else begin
          load       = 1'b1;
          load_found = hit_acc;
          state_next = dws_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dws_pkg::S_IDLE;
      end
    endcase

    if (load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_valid && rsp_stall) begin
      rsp_valid_next = 1'b1;
    end else begin
      rsp_valid_next = 1'b0;
    end
  end

endmodule
